// ===== design/block_delta_encoder_assert.svh =====
// Assertion macros for the block delta encoder.
`ifndef BLOCK_DELTA_ENCODER_ASSERT_SVH
`define BLOCK_DELTA_ENCODER_ASSERT_SVH
`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define BDE_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("block delta encoder: same-cycle check failed");
// Check that cons holds in the cycle after ante.
`define BDE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("block delta encoder: next-cycle check failed");
`else
`define BDE_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define BDE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== design/bde_pkg.sv =====
// Shared types and constants of the block delta encoder.
`default_nettype none
package bde_pkg;
   localparam int unsigned OFFSET_WIDTH_DEF = 32;
   localparam int unsigned MAX_BLOCK_DEF    = 64;
   localparam int unsigned LEN_W            = 32;
   localparam int unsigned BYTE_W           = 8;
   localparam int unsigned BSIZE_W          = 7;
   localparam int unsigned KIND_W           = 2;
   localparam int unsigned REG_IDX_W        = 2;
   localparam int unsigned QUEUE_DEPTH      = 4;
   localparam int unsigned QPTR_W           = $clog2(QUEUE_DEPTH);
   localparam logic [BSIZE_W-1:0] BSIZE_RESET = BSIZE_W'(1);

   localparam logic OP_COMPARE = 1'b0;
   localparam logic OP_FINISH  = 1'b1;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_BLOCK_SIZE = REG_IDX_W'(0),
      REG_OLD_LENGTH = REG_IDX_W'(1),
      REG_NEW_LENGTH = REG_IDX_W'(2)
   } reg_idx_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_UPDATE = KIND_W'(0),
      KIND_DELETE = KIND_W'(1),
      KIND_INSERT = KIND_W'(2)
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [LEN_W-1:0]  start;
      logic [LEN_W-1:0]  length;
   } rec_type;

   // One queue entry: one or two records caused by one input word.
   typedef struct packed {
      logic    two;
      rec_type rec0;
      rec_type rec1;
   } entry_type;

   typedef struct packed {
      logic full;
      logic nonempty;
   } qstat_type;
endpackage
`default_nettype wire

// ===== design/bde_req_if.sv =====
// Request and response channel interfaces of the block delta encoder.
`default_nettype none
interface bde_req_if;
   import bde_pkg::*;
   logic              valid;
   logic              ready;
   logic              op;
   logic [BYTE_W-1:0] old_byte;
   logic [BYTE_W-1:0] new_byte;
   modport source (output valid, output op, output old_byte, output new_byte, input ready);
   modport sink (input valid, input op, input old_byte, input new_byte, output ready);
endinterface

interface bde_rsp_if;
   import bde_pkg::*;
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] record_kind;
   logic [LEN_W-1:0]  record_start;
   logic [LEN_W-1:0]  record_length;
   logic              run_last;
   modport source (output valid, output record_kind, output record_start,
                   output record_length, output run_last, input ready);
   modport sink (input valid, input record_kind, input record_start,
                 input record_length, input run_last, output ready);
endinterface
`default_nettype wire

// ===== design/bde_front.sv =====
// Front end: configuration registers, block and run tracking, record building.
`default_nettype none
module bde_front #(
   parameter int unsigned OFFSET_WIDTH = bde_pkg::OFFSET_WIDTH_DEF,
   parameter int unsigned MAX_BLOCK    = bde_pkg::MAX_BLOCK_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [bde_pkg::REG_IDX_W-1:0] csr_index,
   input  wire logic [bde_pkg::LEN_W-1:0]     csr_wdata,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_op,
   input  wire logic [bde_pkg::BYTE_W-1:0]    req_old_byte,
   input  wire logic [bde_pkg::BYTE_W-1:0]    req_new_byte,
   input  wire bde_pkg::qstat_type            q_stat,
   output logic                               push,
   output bde_pkg::entry_type                 push_entry
);
   import bde_pkg::*;

   localparam int unsigned OW   = OFFSET_WIDTH;
   localparam int unsigned OFFW = $clog2(MAX_BLOCK + 1);
   localparam int unsigned EW   = OFFW + BSIZE_W + 1;
   localparam int unsigned XW   = OW + LEN_W;

   function automatic logic [LEN_W-1:0] to_len(input logic [OW-1:0] v);
      logic [XW-1:0] wide;
      wide = {{LEN_W{1'b0}}, v};
      return wide[LEN_W-1:0];
   endfunction

   logic [BSIZE_W-1:0] block_size_ff;
   logic [LEN_W-1:0]   old_length_ff;
   logic [LEN_W-1:0]   new_length_ff;

   logic [OW-1:0]   pos_ff, pos_in;
   logic [OW-1:0]   block_start_ff, block_start_in;
   logic [OW-1:0]   run_start_ff, run_start_in;
   logic [OFFW-1:0] off_ff, off_in;
   logic            mism_ff, mism_in;
   logic            run_ff, run_in;

   logic [LEN_W-1:0] common;
   logic             in_range;
   logic [EW-1:0]    bs_x;
   logic [EW-1:0]    eff_x;
   logic [OFFW-1:0]  eff;
   logic [OFFW-1:0]  off_inc;
   logic [OW-1:0]    pos_inc;
   logic             cmp_mism;
   logic             accept;
   logic             fin_upd;
   logic [OW-1:0]    fin_rs;
   logic [OW-1:0]    fin_end;
   logic             ext_valid;
   rec_type          ext_rec;
   rec_type          upd_blk;
   rec_type          upd_fin;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff <= BSIZE_RESET;
         old_length_ff <= '0;
         new_length_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_BLOCK_SIZE: block_size_ff <= csr_wdata[BSIZE_W-1:0];
            REG_OLD_LENGTH: old_length_ff <= csr_wdata;
            REG_NEW_LENGTH: new_length_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      common   = (old_length_ff < new_length_ff) ? old_length_ff : new_length_ff;
      in_range = {{LEN_W{1'b0}}, pos_ff} < {{OW{1'b0}}, common};
      // Clamp block size into 1..MAX_BLOCK.
      bs_x = EW'(block_size_ff);
      if (bs_x == '0) begin
         eff_x = EW'(1);
      end else if (bs_x > EW'(MAX_BLOCK)) begin
         eff_x = EW'(MAX_BLOCK);
      end else begin
         eff_x = bs_x;
      end
      eff      = eff_x[OFFW-1:0];
      off_inc  = off_ff + OFFW'(1);
      pos_inc  = pos_ff + OW'(1);
      cmp_mism = mism_ff | (req_old_byte != req_new_byte);
      req_ready = !q_stat.full;
      accept    = req_valid && req_ready;

      upd_blk.kind   = KIND_UPDATE;
      upd_blk.start  = to_len(run_start_ff);
      upd_blk.length = to_len(block_start_ff - run_start_ff);

      // Finish: a dirty partial block opens or extends the run to pos;
      // a clean partial block ends the run at its own start.
      fin_upd = run_ff || ((off_ff != '0) && mism_ff);
      fin_rs  = run_ff ? run_start_ff : block_start_ff;
      fin_end = ((off_ff != '0) && !mism_ff) ? block_start_ff : pos_ff;
      upd_fin.kind   = KIND_UPDATE;
      upd_fin.start  = to_len(fin_rs);
      upd_fin.length = to_len(fin_end - fin_rs);

      ext_valid = old_length_ff != new_length_ff;
      if (old_length_ff > new_length_ff) begin
         ext_rec.kind   = KIND_DELETE;
         ext_rec.start  = new_length_ff;
         ext_rec.length = old_length_ff - new_length_ff;
      end else begin
         ext_rec.kind   = KIND_INSERT;
         ext_rec.start  = old_length_ff;
         ext_rec.length = new_length_ff - old_length_ff;
      end

      pos_in         = pos_ff;
      block_start_in = block_start_ff;
      run_start_in   = run_start_ff;
      off_in         = off_ff;
      mism_in        = mism_ff;
      run_in         = run_ff;
      push           = 1'b0;
      push_entry     = '0;

      if (accept) begin
         if (req_op == OP_COMPARE) begin
            if (in_range) begin
               pos_in  = pos_inc;
               off_in  = off_inc;
               mism_in = cmp_mism;
               if (off_inc >= eff) begin
                  off_in         = '0;
                  mism_in        = 1'b0;
                  block_start_in = pos_inc;
                  if (cmp_mism) begin
                     if (!run_ff) begin
                        run_in       = 1'b1;
                        run_start_in = block_start_ff;
                     end
                  end else if (run_ff) begin
                     run_in          = 1'b0;
                     push            = 1'b1;
                     push_entry.rec0 = upd_blk;
                  end
               end
            end
         end else begin
            if (fin_upd) begin
               push            = 1'b1;
               push_entry.rec0 = upd_fin;
               push_entry.rec1 = ext_rec;
               push_entry.two  = ext_valid;
            end else if (ext_valid) begin
               push            = 1'b1;
               push_entry.rec0 = ext_rec;
            end
            pos_in         = '0;
            block_start_in = '0;
            run_start_in   = '0;
            off_in         = '0;
            mism_in        = 1'b0;
            run_in         = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         block_start_ff <= '0;
         run_start_ff   <= '0;
         off_ff         <= '0;
         mism_ff        <= 1'b0;
         run_ff         <= 1'b0;
      end else begin
         pos_ff         <= pos_in;
         block_start_ff <= block_start_in;
         run_start_ff   <= run_start_in;
         off_ff         <= off_in;
         mism_ff        <= mism_in;
         run_ff         <= run_in;
      end
   end
endmodule
`default_nettype wire

// ===== design/bde_queue.sv =====
// Short entry queue between the front end and the back end.
`default_nettype none
module bde_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire bde_pkg::entry_type push_entry,
   input  wire logic               pop,
   output bde_pkg::entry_type      head,
   output bde_pkg::qstat_type      q_stat
);
   import bde_pkg::*;

   entry_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;

   always_comb begin
      head            = mem_ff[rd_ptr_ff];
      q_stat.full     = count_ff == (QPTR_W + 1)'(QUEUE_DEPTH);
      q_stat.nonempty = count_ff != '0;
      wr_ptr_in       = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in       = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + (QPTR_W + 1)'(1);
         2'b01:   count_in = count_ff - (QPTR_W + 1)'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule
`default_nettype wire

// ===== design/bde_back.sv =====
// Back end: expand queue entries into records and hold the output register.
`default_nettype none
module bde_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire bde_pkg::entry_type head,
   input  wire bde_pkg::qstat_type q_stat,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output bde_pkg::rec_type        rsp_rec,
   output logic                    rsp_last
);
   import bde_pkg::*;

   logic    phase_ff, phase_in;
   logic    valid_ff, valid_in;
   rec_type rec_ff, rec_in;
   logic    last_ff, last_in;
   logic    load;

   always_comb begin
      load     = !valid_ff || rsp_ready;
      phase_in = phase_ff;
      valid_in = valid_ff;
      rec_in   = rec_ff;
      last_in  = last_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = q_stat.nonempty;
         if (q_stat.nonempty) begin
            // Second half of a two-record entry goes out on the next load.
            rec_in   = phase_ff ? head.rec1 : head.rec0;
            last_in  = phase_ff || !head.two;
            pop      = phase_ff || !head.two;
            phase_in = head.two && !phase_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff  <= rec_in;
      last_ff <= last_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_rec   = rec_ff;
   assign rsp_last  = last_ff;
endmodule
`default_nettype wire

// ===== design/block_delta_encoder.sv =====
// Top level of the block delta encoder.
//
//   channel   dir  handshake        word contents
//   req_chan  in   valid / ready    op, old_byte, new_byte
//   rsp_chan  out  valid / ready    record_kind, record_start, record_length, run_last
//   csr_*     in   csr_we only      csr_index, csr_wdata
//
// One input word is taken per cycle while the queue is not full; the front end
// handles a word that closes a block by comparing the pair and updating the run state.
// The back end drains one record per cycle from its output register while
// rsp_chan.ready is high; a finish word with two records sends them one after the other.
// A four-entry queue parts the two ends; req_chan.ready drops only when it is full.
// Reset is synchronous and active high; it clears the stream state and sets
// block_size to 1 and both lengths to 0.
`default_nettype none
`include "block_delta_encoder_assert.svh"
module block_delta_encoder #(
   parameter int unsigned OFFSET_WIDTH = bde_pkg::OFFSET_WIDTH_DEF,
   parameter int unsigned MAX_BLOCK    = bde_pkg::MAX_BLOCK_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [bde_pkg::REG_IDX_W-1:0] csr_index,
   input  wire logic [bde_pkg::LEN_W-1:0]     csr_wdata,
   bde_req_if.sink                            req_chan,
   bde_rsp_if.source                          rsp_chan
);
   import bde_pkg::*;

   // Front end to queue.
   logic      push;
   entry_type push_entry;
   qstat_type q_stat;

   // Queue to back end.
   entry_type head;
   logic      pop;
   rec_type   rsp_rec;
   logic      req_ready;
   logic      rsp_valid;
   logic      rsp_last;

   // Classify each word, track blocks and runs, build the records.
   bde_front #(
      .OFFSET_WIDTH (OFFSET_WIDTH),
      .MAX_BLOCK    (MAX_BLOCK)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_chan.valid),
      .req_ready    (req_ready),
      .req_op       (req_chan.op),
      .req_old_byte (req_chan.old_byte),
      .req_new_byte (req_chan.new_byte),
      .q_stat       (q_stat),
      .push         (push),
      .push_entry   (push_entry)
   );

   // Hold records while the output side stalls.
   bde_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_stat     (q_stat)
   );

   // Advance one record per cycle toward the output register while it is empty or taken.
   bde_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_stat    (q_stat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_rec   (rsp_rec),
      .rsp_last  (rsp_last)
   );

   assign req_chan.ready         = req_ready;
   assign rsp_chan.valid         = rsp_valid;
   assign rsp_chan.record_kind   = rsp_rec.kind;
   assign rsp_chan.record_start  = rsp_rec.start;
   assign rsp_chan.record_length = rsp_rec.length;
   assign rsp_chan.run_last      = rsp_last;

   // A two-record entry is always an update followed by a delete or insert.
   `BDE_ASSERT_NOW(a_two_rec_order, clock, reset, push && push_entry.two, push_entry.rec0.kind == KIND_UPDATE && push_entry.rec1.kind != KIND_UPDATE)
   // A compare word yields at most one update record.
   `BDE_ASSERT_NOW(a_cmp_single_update, clock, reset, push && req_chan.valid && req_ready && req_chan.op == OP_COMPARE, !push_entry.two && push_entry.rec0.kind == KIND_UPDATE)
   // Delete and insert records always close their word.
   `BDE_ASSERT_NOW(a_ext_is_last, clock, reset, rsp_valid && rsp_chan.record_kind != KIND_UPDATE, rsp_last)
   // After a non-last record is taken, the length record follows at once.
   `BDE_ASSERT_NEXT(a_second_follows, clock, reset, rsp_valid && rsp_chan.ready && !rsp_last, rsp_valid && rsp_chan.record_kind != KIND_UPDATE)
endmodule
`default_nettype wire
